### rtl/vrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_pkg
// shared widths, register codes and stage payload types for the vertex
// rotate and project pipeline
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int COORD_W  = 16;
   localparam int TRIG_W   = 16;
   localparam int DIST_W   = 15;
   localparam int SCALE_W  = 16;
   localparam int CSR_W    = 16;
   localparam int R1_W     = 19;
   localparam int R2_W     = 22;
   localparam int DEN_W    = 23;
   localparam int NUM_W    = 43;
   localparam int DIV_W    = 46;
   localparam int DVS_W    = 24;
   localparam int QUO_BITS = 21;
   localparam int SCR_W    = 20;

   typedef enum logic [1:0] {
      REG_COS   = 2'd0,
      REG_SIN   = 2'd1,
      REG_DIST  = 2'd2,
      REG_SCALE = 2'd3
   } reg_index_type;

   localparam logic [TRIG_W-1:0]  COS_RESET   = 16'd16384;
   localparam logic [TRIG_W-1:0]  SIN_RESET   = 16'd0;
   localparam logic [DIST_W-1:0]  DIST_RESET  = 15'd20480;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

   localparam logic [QUO_BITS-1:0] POS_LIMIT = QUO_BITS'(2**(SCR_W-1) - 1);
   localparam logic [QUO_BITS-1:0] NEG_LIMIT = QUO_BITS'(2**(SCR_W-1));
   localparam logic [SCR_W-1:0]    SCR_MAX   = {1'b0, {(SCR_W-1){1'b1}}};
   localparam logic [SCR_W-1:0]    SCR_MIN   = {1'b1, {(SCR_W-1){1'b0}}};

   typedef struct packed {
      logic signed [R1_W-1:0]  x1;
      logic signed [R2_W-1:0]  y2;
      logic signed [DEN_W-1:0] den;
   } rot_type;

   typedef struct packed {
      logic [QUO_BITS-1:0] quo_x;
      logic [QUO_BITS-1:0] quo_y;
      logic                ovf_x;
      logic                ovf_y;
      logic                neg_x;
      logic                neg_y;
      logic                fault;
   } quo_type;

endpackage
`default_nettype wire

### rtl/vertex_rotate_project_core.sv
// path from an accepted req beat to its rsp beat
// (4 rotate stages, 2 scale/sign stages, 21 divider stages, 1 output register)
// throughput: one vertex per cycle while not held; the divider retires one quotient bit per stage
// the whole pipeline holds while a rsp beat waits and the output register is full
// reset is synchronous and active high; it empties the pipeline and loads the
// register defaults (cos 1.0, sin 0, distance 5.0, scale 1000)
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// rotates a q4.12 vertex about y then x and projects it to q16.4 screen space
// ----------------------------------------------------------------------------
module vertex_rotate_project_core import vrp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [47:0]      req_tdata,   // point_x, point_y, point_z
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [39:0]           rsp_tdata,   // screen_x, screen_y
   output logic [1:0]            rsp_tuser,   // depth_fault, saturated
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   logic [TRIG_W-1:0]  cos_ff, sin_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               en;
   logic               rot_valid, div_valid;
   rot_type            rot;
   quo_type            quo;
   logic               rsp_valid_ff;
   logic [SCR_W-1:0]   sx_ff, sy_ff, sx_in, sy_in;
   logic               fault_ff, sat_ff, sat_x_in, sat_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= COS_RESET;
         sin_ff   <= SIN_RESET;
         dist_ff  <= DIST_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_wen) begin
         case (reg_index_type'(csr_index))
            REG_COS:   cos_ff   <= csr_wdata;
            REG_SIN:   sin_ff   <= csr_wdata;
            REG_DIST:  dist_ff  <= csr_wdata[DIST_W-1:0];
            REG_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   vrp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .point_x   (signed'(req_tdata[15:0])),
      .point_y   (signed'(req_tdata[31:16])),
      .point_z   (signed'(req_tdata[47:32])),
      .cos_value (signed'(cos_ff)),
      .sin_value (signed'(sin_ff)),
      .view_dist (dist_ff),
      .out_valid (rot_valid),
      .out_rot   (rot)
   );

   vrp_divide u_divide (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (rot_valid),
      .in_rot       (rot),
      .screen_scale (scale_ff),
      .out_valid    (div_valid),
      .out_quo      (quo)
   );

   always_comb begin
      sat_x_in = quo.ovf_x || (quo.neg_x ? quo.quo_x > NEG_LIMIT : quo.quo_x > POS_LIMIT);
      sat_y_in = quo.ovf_y || (quo.neg_y ? quo.quo_y > NEG_LIMIT : quo.quo_y > POS_LIMIT);
      if (sat_x_in) begin
         sx_in = quo.neg_x ? SCR_MIN : SCR_MAX;
      end else begin
         sx_in = quo.neg_x ? SCR_W'(-quo.quo_x) : SCR_W'(quo.quo_x);
      end
      if (sat_y_in) begin
         sy_in = quo.neg_y ? SCR_MIN : SCR_MAX;
      end else begin
         sy_in = quo.neg_y ? SCR_W'(-quo.quo_y) : SCR_W'(quo.quo_y);
      end
      if (quo.fault) begin
         sx_in    = '0;
         sy_in    = '0;
         sat_x_in = 1'b0;
         sat_y_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         fault_ff <= quo.fault;
         sat_ff   <= sat_x_in || sat_y_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sy_ff, sx_ff};
   assign rsp_tuser  = {sat_ff, fault_ff};

   a_fault_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("depth fault beat carries nonzero data");

   a_sat_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         sx_ff == SCR_MAX || sx_ff == SCR_MIN || sy_ff == SCR_MAX || sy_ff == SCR_MIN)
      else $error("saturated beat without a clamped coordinate");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_ready_follows : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

endmodule
`default_nettype wire

### rtl/vrp_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_rotate
// four stage rotation about y then x, with q14 rounding, and divisor sum
// ----------------------------------------------------------------------------
module vrp_rotate import vrp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic signed [COORD_W-1:0] point_x,
   input  wire logic signed [COORD_W-1:0] point_y,
   input  wire logic signed [COORD_W-1:0] point_z,
   input  wire logic signed [TRIG_W-1:0]  cos_value,
   input  wire logic signed [TRIG_W-1:0]  sin_value,
   input  wire logic [DIST_W-1:0]         view_dist,
   output logic                           out_valid,
   output rot_type                        out_rot
);

   logic                           v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_W-1:0]      y1_ff, y2s_ff;
   logic signed [31:0]             xc_ff, zs_ff, zc_ff, xs_ff;
   logic signed [33:0]             sum_x_in, sum_z_in;
   logic signed [R1_W-1:0]         x1_in, z1_in, x1_ff, z1_ff, x1b_ff;
   logic signed [31:0]             yc_ff, ys_ff;
   logic signed [34:0]             z1s_ff, z1c_ff;
   logic signed [36:0]             sum_y2_in, sum_z2_in;
   logic signed [R2_W-1:0]         y2_in, z2_in;
   logic signed [DEN_W-1:0]        den_in;
   rot_type                        rot_ff;

   always_comb begin
      sum_x_in  = 34'(xc_ff) + 34'(zs_ff) + 34'sd8192;
      sum_z_in  = 34'(zc_ff) - 34'(xs_ff) + 34'sd8192;
      x1_in     = R1_W'(sum_x_in >>> 14);
      z1_in     = R1_W'(sum_z_in >>> 14);
      sum_y2_in = 37'(yc_ff) - 37'(z1s_ff) + 37'sd8192;
      sum_z2_in = 37'(ys_ff) + 37'(z1c_ff) + 37'sd8192;
      y2_in     = R2_W'(sum_y2_in >>> 14);
      z2_in     = R2_W'(sum_z2_in >>> 14);
      den_in    = DEN_W'(z2_in) + DEN_W'(signed'({1'b0, view_dist}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xc_ff      <= point_x * cos_value;
         zs_ff      <= point_z * sin_value;
         zc_ff      <= point_z * cos_value;
         xs_ff      <= point_x * sin_value;
         y1_ff      <= point_y;
         x1_ff      <= x1_in;
         z1_ff      <= z1_in;
         y2s_ff     <= y1_ff;
         yc_ff      <= y2s_ff * cos_value;
         ys_ff      <= y2s_ff * sin_value;
         z1s_ff     <= z1_ff * sin_value;
         z1c_ff     <= z1_ff * cos_value;
         x1b_ff     <= x1_ff;
         rot_ff.x1  <= x1b_ff;
         rot_ff.y2  <= y2_in;
         rot_ff.den <= den_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rot   = rot_ff;

endmodule
`default_nettype wire

### rtl/vrp_divide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_divide
// scale multiply, sign split and a restoring divider with one quotient bit
// per stage, shared divisor for x and y
// ----------------------------------------------------------------------------
module vrp_divide import vrp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire rot_type            in_rot,
   input  wire logic [SCALE_W-1:0] screen_scale,
   output logic                    out_valid,
   output quo_type                 out_quo
);

   typedef struct packed {
      logic ovf_x;
      logic ovf_y;
      logic neg_x;
      logic neg_y;
      logic fault;
   } flag_type;

   logic signed [SCALE_W+4:0] k_in;
   logic                      va_ff;
   logic signed [NUM_W-1:0]   numx_ff, numy_ff;
   logic signed [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]          absx_in, absy_in;
   logic [DEN_W-1:0]          absd_in;
   logic [DVS_W-1:0]          dvs_in;
   logic [DIV_W-1:0]          nx_in, ny_in, lim_in;
   flag_type                  flag_in;

   logic                      v_ff    [QUO_BITS+1];
   logic [DIV_W-1:0]          remx_ff [QUO_BITS+1];
   logic [DIV_W-1:0]          remy_ff [QUO_BITS+1];
   logic [DVS_W-1:0]          dvs_ff  [QUO_BITS+1];
   logic [QUO_BITS-1:0]       qx_ff   [QUO_BITS+1];
   logic [QUO_BITS-1:0]       qy_ff   [QUO_BITS+1];
   flag_type                  flag_ff [QUO_BITS+1];

   always_comb begin
      k_in    = signed'({1'b0, screen_scale, 4'b0000});
      absx_in = numx_ff[NUM_W-1] ? NUM_W'(-numx_ff) : NUM_W'(numx_ff);
      absy_in = numy_ff[NUM_W-1] ? NUM_W'(-numy_ff) : NUM_W'(numy_ff);
      absd_in = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
      dvs_in  = {absd_in, 1'b0};
      nx_in   = (DIV_W'(absx_in) << 1) + DIV_W'(absd_in);
      ny_in   = (DIV_W'(absy_in) << 1) + DIV_W'(absd_in);
      lim_in  = DIV_W'(dvs_in) << QUO_BITS;
      flag_in.ovf_x = nx_in >= lim_in;
      flag_in.ovf_y = ny_in >= lim_in;
      flag_in.neg_x = numx_ff[NUM_W-1] ^ den_ff[DEN_W-1];
      flag_in.neg_y = numy_ff[NUM_W-1] ^ den_ff[DEN_W-1];
      flag_in.fault = den_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (en) begin
         va_ff   <= in_valid;
         v_ff[0] <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff    <= NUM_W'(in_rot.x1 * k_in);
         numy_ff    <= NUM_W'(in_rot.y2 * k_in);
         den_ff     <= in_rot.den;
         remx_ff[0] <= nx_in;
         remy_ff[0] <= ny_in;
         dvs_ff[0]  <= dvs_in;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         flag_ff[0] <= flag_in;
      end
   end

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
      localparam int SH = QUO_BITS - 1 - g;
      logic [DIV_W-1:0] trial_in, remx_in, remy_in;
      logic             bx_in, by_in;

      always_comb begin
         trial_in = DIV_W'(dvs_ff[g]) << SH;
         bx_in    = remx_ff[g] >= trial_in;
         by_in    = remy_ff[g] >= trial_in;
         remx_in  = bx_in ? remx_ff[g] - trial_in : remx_ff[g];
         remy_in  = by_in ? remy_ff[g] - trial_in : remy_ff[g];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (en) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            remx_ff[g+1] <= remx_in;
            remy_ff[g+1] <= remy_in;
            dvs_ff[g+1]  <= dvs_ff[g];
            qx_ff[g+1]   <= {qx_ff[g][QUO_BITS-2:0], bx_in};
            qy_ff[g+1]   <= {qy_ff[g][QUO_BITS-2:0], by_in};
            flag_ff[g+1] <= flag_ff[g];
         end
      end
   end

   assign out_valid     = v_ff[QUO_BITS];
   assign out_quo.quo_x = qx_ff[QUO_BITS];
   assign out_quo.quo_y = qy_ff[QUO_BITS];
   assign out_quo.ovf_x = flag_ff[QUO_BITS].ovf_x;
   assign out_quo.ovf_y = flag_ff[QUO_BITS].ovf_y;
   assign out_quo.neg_x = flag_ff[QUO_BITS].neg_x;
   assign out_quo.neg_y = flag_ff[QUO_BITS].neg_y;
   assign out_quo.fault = flag_ff[QUO_BITS].fault;

endmodule
`default_nettype wire

### tb/vertex_rotate_project_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_checker
// watches the req and rsp channels and the csr port, computes the expected
// screen coordinates and flags of every accepted vertex and compares them
// with the rsp beats in order
// ----------------------------------------------------------------------------
module vertex_rotate_project_checker import vrp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [47:0]      req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [39:0]      rsp_tdata,
   input  wire logic [1:0]       rsp_tuser,
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count,
   output int                    point_count,
   output int                    sat_count,
   output int                    fault_count
);

   typedef struct packed {
      logic [SCR_W-1:0] sx;
      logic [SCR_W-1:0] sy;
      logic             fault;
      logic             sat;
   } screen_type;

   logic signed [15:0] cos_q;
   logic signed [15:0] sin_q;
   logic [14:0]        dist_q;
   logic [15:0]        scale_q;
   screen_type         expected_screen[$];

   function automatic longint round_q14(longint v);
      longint t;
      t = v + 8192;
      if (t >= 0) return t / 16384;
      return -((-t + 16383) / 16384);
   endfunction

   function automatic longint nearest_div(longint num, longint den);
      longint an, ad, q;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic screen_type project_point(logic [47:0] d);
      longint x, y, z, c, s, x1, z1, y2, z2, den, k, vx, vy;
      screen_type r;
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      c = longint'(cos_q);
      s = longint'(sin_q);
      x1 = round_q14(x * c + z * s);
      z1 = round_q14(z * c - x * s);
      y2 = round_q14(y * c - z1 * s);
      z2 = round_q14(y * s + z1 * c);
      den = z2 + longint'(dist_q);
      r = '0;
      if (den == 0) begin
         r.fault = 1'b1;
      end else begin
         k = longint'(scale_q) * 16;
         vx = nearest_div(x1 * k, den);
         vy = nearest_div(y2 * k, den);
         if (vx > 524287) begin vx = 524287; r.sat = 1'b1; end
         if (vx < -524288) begin vx = -524288; r.sat = 1'b1; end
         if (vy > 524287) begin vy = 524287; r.sat = 1'b1; end
         if (vy < -524288) begin vy = -524288; r.sat = 1'b1; end
         r.sx = vx[SCR_W-1:0];
         r.sy = vy[SCR_W-1:0];
      end
      return r;
   endfunction

   assign pending_count = expected_screen.size();

   always @(posedge clock) begin
      screen_type e;
      int         errs;
      errs = 0;
      if (reset) begin
         cos_q <= COS_RESET;
         sin_q <= SIN_RESET;
         dist_q <= DIST_RESET;
         scale_q <= SCALE_RESET;
         expected_screen.delete();
         error_count <= 0;
         point_count <= 0;
         sat_count <= 0;
         fault_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            e = project_point(req_tdata);
            expected_screen.push_back(e);
            point_count <= point_count + 1;
            if (e.sat) sat_count <= sat_count + 1;
            if (e.fault) fault_count <= fault_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_screen.size() == 0) begin
               $error("rsp beat with nothing expected");
               errs++;
            end else begin
               e = expected_screen.pop_front();
               if (rsp_tdata[19:0] !== e.sx) begin
                  $error("screen_x expected %h actual %h", e.sx, rsp_tdata[19:0]);
                  errs++;
               end
               if (rsp_tdata[39:20] !== e.sy) begin
                  $error("screen_y expected %h actual %h", e.sy, rsp_tdata[39:20]);
                  errs++;
               end
               if (rsp_tuser[0] !== e.fault) begin
                  $error("depth_fault expected %b actual %b", e.fault, rsp_tuser[0]);
                  errs++;
               end
               if (rsp_tuser[1] !== e.sat) begin
                  $error("saturated expected %b actual %b", e.sat, rsp_tuser[1]);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
         if (csr_wen) begin
            case (reg_index_type'(csr_index))
               REG_COS: cos_q <= csr_wdata;
               REG_SIN: sin_q <= csr_wdata;
               REG_DIST: dist_q <= csr_wdata[14:0];
               REG_SCALE: scale_q <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

### tb/tb_vertex_rotate_project_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project_core
// drives directed and random vertices through several rotation, distance and
// scale settings with random idling on both channels and a long rsp hold-off;
// the checker predicts and compares every rsp beat
// ----------------------------------------------------------------------------
module tb_vertex_rotate_project_core;
   import vrp_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [47:0]      req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             csr_wen = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   int               error_count, pending_count, point_count, sat_count, fault_count;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_cycles = 0;

   always #2 clock = ~clock;

   vertex_rotate_project_core dut (.*);

   vertex_rotate_project_checker checker_i (.*);

   // rsp side: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ready is stable from the falling edge up to the next rising edge
   task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      @(negedge clock);
      while (!req_tready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [15:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_view(logic [15:0] c, logic [15:0] s, logic [15:0] d,
                           logic [15:0] k);
      drain();
      write_csr(REG_COS, c);
      write_csr(REG_SIN, s);
      write_csr(REG_DIST, d);
      write_csr(REG_SCALE, k);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'($signed($urandom_range(8192)) - 4096);
         2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($signed($urandom_range(65535)) >>> $urandom_range(15));
      endcase
   endfunction

   task automatic random_points(int n);
      for (int i = 0; i < n; i++) begin
         send_point(rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers, extremes, zero divisor, negative divisor
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h7fff, 16'h7fff, 16'h7fff);
      send_point(16'h8000, 16'h8000, 16'h8000);
      send_point(16'h7fff, 16'h8000, 16'hb000);
      send_point(16'h1000, 16'hf000, 16'hb000);
      send_point(16'h1000, 16'h1000, 16'h8000);
      send_point(16'h7fff, 16'h7fff, 16'hb001);
      send_point(16'hffff, 16'h0001, 16'h0000);
      set_view(16'h2d41, 16'h2d41, 16'd0, 16'hffff);
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h1000, 16'h1000, 16'h1000);
      send_point(16'h8000, 16'h7fff, 16'h0001);
      set_view(16'hc000, 16'h4000, 16'h7fff, 16'd0);
      send_point(16'h7fff, 16'h8000, 16'h7fff);
      send_point(16'h1234, 16'h5678, 16'h9abc);
      set_view(16'h7fff, 16'h8000, 16'h7fff, 16'd1);
      send_point(16'h7fff, 16'h7fff, 16'h8000);
      send_point(16'h8000, 16'h8000, 16'h7fff);
      set_view(16'h0000, 16'hc000, 16'h0001, 16'hffff);
      send_point(16'h0001, 16'hffff, 16'h0000);
      send_point(16'h4000, 16'h4000, 16'h4000);

      // random phases with changing idling and settings
      for (phase = 0; phase < 8; phase++) begin
         set_view(16'($signed($urandom_range(32768)) - 16384),
                  16'($signed($urandom_range(32768)) - 16384),
                  16'($urandom_range(1) ? $urandom_range(32767) : $urandom_range(200)),
                  16'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(3000)));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         if (phase == 4) hold_cycles <= 300;
         random_points(180);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_view(16'h4000, 16'h0000, 16'h5000, 16'd1000);
      drain();
      $display("covered %0d vertices, %0d saturated, %0d depth faults",
               point_count, sat_count, fault_count);
      if (error_count == 0) begin
         $display("tb_vertex_rotate_project_core passed");
      end else begin
         $display("tb_vertex_rotate_project_core failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_vertex_rotate_project_core failed");
      $finish;
   end

endmodule
